/* sv/dcc_ser_pkg.sv */
// Shared types, codes and packet helpers for the DCC speed packet serializer.
// Depends on nothing; design files use scoped names, testbench files import it.
package dcc_ser_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 5;
    localparam int unsigned POS_W       = 7;

    // operation codes
    localparam logic [1:0] OP_THROTTLE  = 2'd0;
    localparam logic [1:0] OP_RESET_PKT = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSER   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POWER    = 2'd2;

    localparam logic [4:0]  PREAMBLE_RESET = 5'd16;
    localparam logic [3:0]  CLOSER_RESET   = 4'd1;

    localparam logic [13:0] SHORT_ADDR_MAX = 14'd127;
    localparam logic [7:0]  INSTR_BASE     = 8'h40;
    localparam logic [7:0]  LONG_PREFIX    = 8'hC0;

    // start bit plus eight data bits per byte
    localparam logic [POS_W-1:0] SHORT_BODY_BITS = 7'd27;
    localparam logic [POS_W-1:0] LONG_BODY_BITS  = 7'd36;

    typedef logic [3:0][7:0] dcc_ser_bytes_t;

    // bytes[0] goes out first: FF 00 FF
    localparam dcc_ser_bytes_t IDLE_BYTES = 32'h00FF_00FF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [13:0] locomotive_address;
        logic [4:0]  speed_step;
        logic        direction_bit;
    } dcc_ser_cmd_t;

    typedef struct packed {
        logic bit_valid;
        logic line_bit;
        logic packet_last;
        logic long_form;
        logic accepted;
    } dcc_ser_res_t;

    typedef struct packed {
        logic [4:0] preamble_bits;
        logic [3:0] closer_bits;
        logic       track_power;
    } dcc_ser_cfg_t;

    typedef struct packed {
        dcc_ser_bytes_t bytes;
        logic           long_form;
    } dcc_ser_packet_t;

    function automatic dcc_ser_packet_t build_packet(
        input logic [13:0] addr,
        input logic [4:0]  speed,
        input logic        dir
    );
        logic [7:0]      instr;
        logic [7:0]      hi;
        logic [7:0]      lo;
        dcc_ser_packet_t p;
        instr = INSTR_BASE | {2'b00, dir, speed};
        hi    = LONG_PREFIX | {2'b00, addr[13:8]};
        lo    = addr[7:0];
        if (addr > SHORT_ADDR_MAX)
        begin
            p.bytes[0]  = hi;
            p.bytes[1]  = lo;
            p.bytes[2]  = instr;
            p.bytes[3]  = hi ^ lo ^ instr;
            p.long_form = 1'b1;
        end
        else
        begin
            p.bytes[0]  = lo;
            p.bytes[1]  = instr;
            p.bytes[2]  = lo ^ instr;
            p.bytes[3]  = 8'h00;
            p.long_form = 1'b0;
        end
        return p;
    endfunction

    // total bits of one packet including preamble and closing ones
    function automatic logic [POS_W-1:0] packet_len(
        input logic       long_form,
        input logic [4:0] preamble,
        input logic [3:0] closer
    );
        logic [3:0] closer_eff;
        closer_eff = (closer == 4'd0) ? 4'd1 : closer;
        return {2'b00, preamble} + (long_form ? LONG_BODY_BITS : SHORT_BODY_BITS)
               + {3'b000, closer_eff};
    endfunction

endpackage

/* sv/dcc_ser_cfg.sv */
// Configuration register file: preamble length, closer length, track power.
// Depends on dcc_ser_pkg.
module dcc_ser_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcc_ser_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dcc_ser_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dcc_ser_pkg::dcc_ser_cfg_t           cfg
);

    dcc_ser_pkg::dcc_ser_cfg_t cfg_reg;
    dcc_ser_pkg::dcc_ser_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dcc_ser_pkg::REG_PREAMBLE: cfg_next.preamble_bits = cfg_data[4:0];
                dcc_ser_pkg::REG_CLOSER:   cfg_next.closer_bits   = cfg_data[3:0];
                dcc_ser_pkg::REG_POWER:    cfg_next.track_power   = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_bits <= dcc_ser_pkg::PREAMBLE_RESET;
            cfg_reg.closer_bits   <= dcc_ser_pkg::CLOSER_RESET;
            cfg_reg.track_power   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/dcc_ser_engine.sv */
// Packet state and per-word logic: loads the pending packet, swaps it in at
// a packet boundary and picks the track bit for each tick. Depends on dcc_ser_pkg.
module dcc_ser_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  dcc_ser_pkg::dcc_ser_cmd_t cmd,
    input  dcc_ser_pkg::dcc_ser_cfg_t cfg,
    output dcc_ser_pkg::dcc_ser_res_t res
);

    dcc_ser_pkg::dcc_ser_bytes_t          pending_bytes_reg;
    dcc_ser_pkg::dcc_ser_bytes_t          pending_bytes_next;
    logic                                 pending_long_reg;
    logic                                 pending_long_next;
    logic                                 pending_valid_reg;
    logic                                 pending_valid_next;
    dcc_ser_pkg::dcc_ser_bytes_t          current_bytes_reg;
    dcc_ser_pkg::dcc_ser_bytes_t          current_bytes_next;
    logic                                 current_long_reg;
    logic                                 current_long_next;
    logic [dcc_ser_pkg::POS_W-1:0]        pos_reg;
    logic [dcc_ser_pkg::POS_W-1:0]        pos_next;

    dcc_ser_pkg::dcc_ser_packet_t         built;
    logic [dcc_ser_pkg::POS_W-1:0]        len_cur;
    logic [dcc_ser_pkg::POS_W-1:0]        len_sel;
    logic [dcc_ser_pkg::POS_W-1:0]        pos_eff;
    logic [dcc_ser_pkg::POS_W-1:0]        pos_inc;
    logic [dcc_ser_pkg::POS_W-1:0]        body_off;
    logic [dcc_ser_pkg::POS_W-1:0]        body_bits;
    logic                                 swap;
    dcc_ser_pkg::dcc_ser_bytes_t          sel_bytes;
    logic                                 sel_long;
    logic [1:0]                           byte_idx;
    logic [3:0]                           bit_off;
    logic [2:0]                           bit_idx;
    logic [7:0]                           byte_sel;
    logic                                 tick_bit;
    logic                                 tick_last;
    logic                                 is_load;
    logic                                 is_tick;

    assign built   = dcc_ser_pkg::build_packet(cmd.locomotive_address, cmd.speed_step,
                                               cmd.direction_bit);
    assign is_load = cfg.track_power && (cmd.operation == dcc_ser_pkg::OP_THROTTLE ||
                                         cmd.operation == dcc_ser_pkg::OP_RESET_PKT);
    assign is_tick = cfg.track_power && (cmd.operation == dcc_ser_pkg::OP_TICK);

    // a position left past the end by a register change counts as a boundary
    assign len_cur   = dcc_ser_pkg::packet_len(current_long_reg, cfg.preamble_bits,
                                               cfg.closer_bits);
    assign pos_eff   = (pos_reg >= len_cur) ? '0 : pos_reg;
    assign swap      = (pos_eff == '0) && pending_valid_reg;
    assign sel_bytes = swap ? pending_bytes_reg : current_bytes_reg;
    assign sel_long  = swap ? pending_long_reg : current_long_reg;
    assign len_sel   = dcc_ser_pkg::packet_len(sel_long, cfg.preamble_bits,
                                               cfg.closer_bits);
    assign pos_inc   = pos_eff + 7'd1;
    assign tick_last = (pos_inc >= len_sel);

    assign body_off  = pos_eff - {2'b00, cfg.preamble_bits};
    assign body_bits = sel_long ? dcc_ser_pkg::LONG_BODY_BITS
                                : dcc_ser_pkg::SHORT_BODY_BITS;

    // split body offset into byte number and bit slot (slot 0 is the start bit)
    always_comb
    begin
        if (body_off < 7'd9)
        begin
            byte_idx = 2'd0;
            bit_off  = body_off[3:0];
        end
        else if (body_off < 7'd18)
        begin
            byte_idx = 2'd1;
            bit_off  = 4'(body_off - 7'd9);
        end
        else if (body_off < 7'd27)
        begin
            byte_idx = 2'd2;
            bit_off  = 4'(body_off - 7'd18);
        end
        else
        begin
            byte_idx = 2'd3;
            bit_off  = 4'(body_off - 7'd27);
        end
    end

    assign byte_sel = sel_bytes[byte_idx];
    assign bit_idx  = 3'(4'd8 - bit_off);

    always_comb
    begin
        if (pos_eff < {2'b00, cfg.preamble_bits})
            tick_bit = 1'b1;
        else if (body_off < body_bits)
            tick_bit = (bit_off == 4'd0) ? 1'b0 : byte_sel[bit_idx];
        else
            tick_bit = 1'b1;
    end

    always_comb
    begin
        pending_bytes_next = pending_bytes_reg;
        pending_long_next  = pending_long_reg;
        pending_valid_next = pending_valid_reg;
        current_bytes_next = current_bytes_reg;
        current_long_next  = current_long_reg;
        pos_next           = pos_reg;
        res                = '0;
        if (fire && is_load)
        begin
            if (cmd.operation == dcc_ser_pkg::OP_THROTTLE)
            begin
                pending_bytes_next = built.bytes;
                pending_long_next  = built.long_form;
            end
            else
            begin
                pending_bytes_next = '0;
                pending_long_next  = 1'b0;
            end
            pending_valid_next = 1'b1;
            res.accepted       = 1'b1;
            res.long_form      = pending_long_next;
        end
        else if (fire && is_tick)
        begin
            if (swap)
            begin
                current_bytes_next = pending_bytes_reg;
                current_long_next  = pending_long_reg;
                pending_valid_next = 1'b0;
            end
            pos_next        = tick_last ? '0 : pos_inc;
            res.bit_valid   = 1'b1;
            res.line_bit    = tick_bit;
            res.packet_last = tick_last;
            res.long_form   = sel_long;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_long_reg  <= 1'b0;
            pending_valid_reg <= 1'b0;
            current_bytes_reg <= dcc_ser_pkg::IDLE_BYTES;
            current_long_reg  <= 1'b0;
            pos_reg           <= '0;
        end
        else
        begin
            pending_long_reg  <= pending_long_next;
            pending_valid_reg <= pending_valid_next;
            current_bytes_reg <= current_bytes_next;
            current_long_reg  <= current_long_next;
            pos_reg           <= pos_next;
        end
    end

    // read only after a load has written it
    always_ff @(posedge clk)
    begin
        pending_bytes_reg <= pending_bytes_next;
    end

endmodule

/* sv/dcc_speed_packet_serializer.sv */
// DCC speed/direction packet serializer, top level with command and result registers.
// Depends on dcc_ser_pkg, dcc_ser_cfg and dcc_ser_engine.
//
// Takes one command word per clock unless cmd_stall is set: throttle loads and
// reset-packet requests stage a pending packet, bit ticks emit one track bit
// each, MSB first, with preamble ones, a zero start bit before every byte and
// closing ones. A pending packet replaces the current one at the next packet
// boundary; the current packet repeats until then (the idle packet FF 00 FF
// after reset). Every command word yields exactly one result word, taken from
// the command register into the result register. One word per cycle is
// sustained while res_stall is low: the whole per-word update of the packet
// state and bit position happens combinationally between the command register
// and the result register. Configuration writes are always ready and must be
// made while no word is in flight.
module dcc_speed_packet_serializer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  dcc_ser_pkg::dcc_ser_cmd_t           cmd_word,
    output logic                                res_valid,
    input  logic                                res_stall,
    output dcc_ser_pkg::dcc_ser_res_t           res_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcc_ser_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dcc_ser_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                      cmd_valid_reg;
    logic                      cmd_valid_next;
    dcc_ser_pkg::dcc_ser_cmd_t cmd_reg;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    dcc_ser_pkg::dcc_ser_res_t res_reg;
    dcc_ser_pkg::dcc_ser_res_t res_comb;
    dcc_ser_pkg::dcc_ser_cfg_t cfg;
    logic                      advance;
    logic                      fire;
    logic                      take;

    // result register free or being drained this cycle
    assign advance   = !res_valid_reg || !res_stall;
    assign fire      = cmd_valid_reg && advance;
    assign cmd_stall = cmd_valid_reg && !advance;
    assign take      = cmd_valid && !cmd_stall;

    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (take)
            cmd_valid_next = 1'b1;
        else if (advance)
            cmd_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (fire)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    dcc_ser_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcc_ser_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cmd   (cmd_reg),
        .cfg   (cfg),
        .res   (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd_word;
        if (fire)
            res_reg <= res_comb;
    end

endmodule

/* sv/dcc_ser_checker.sv */
// Port-level checks for the DCC speed packet serializer, bound to the top level.
// Depends on dcc_ser_pkg and dcc_speed_packet_serializer.
module dcc_ser_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cmd_stall,
    input logic                                res_valid,
    input logic                                res_stall,
    input dcc_ser_pkg::dcc_ser_res_t           res_word
);

    // a stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("result word changed while stalled");

    // commands back up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid && res_stall)
        else $error("command stall without result backpressure");

    // a load result never carries a track bit
    a_load_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.accepted |-> !res_word.bit_valid && !res_word.packet_last)
        else $error("load result carries a track bit");

    // the final bit of a packet is a closing one
    a_last_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.packet_last |-> res_word.bit_valid && res_word.line_bit)
        else $error("packet end on a non-closing bit");

    // line bit only with a valid track bit
    a_bit_gated: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.line_bit |-> res_word.bit_valid)
        else $error("line bit set without bit_valid");

endmodule

bind dcc_speed_packet_serializer dcc_ser_checker u_dcc_ser_checker (.*);

/* tb/sv/dcc_bitstream_checker.sv */
// Result checker for dcc_speed_packet_serializer: tracks register writes and
// accepted command words, predicts each result word and compares in order.
// Depends on dcc_ser_pkg.
module dcc_bitstream_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  logic                                cmd_stall,
    input  dcc_ser_pkg::dcc_ser_cmd_t           cmd_word,
    input  logic                                res_valid,
    input  logic                                res_stall,
    input  dcc_ser_pkg::dcc_ser_res_t           res_word,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [dcc_ser_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dcc_ser_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                  mismatches,
    output int                                  words_due
);
    import dcc_ser_pkg::*;

    dcc_ser_cfg_t  regs;
    logic [7:0]    staged_bytes [4];
    logic          staged_long;
    logic          staged_valid;
    logic [7:0]    line_bytes [4];
    logic          line_long;
    int unsigned   bit_pos;
    dcc_ser_res_t  track_words_q [$];
    int            errors;

    // advances the serializer state by one command word, returns its result word
    task automatic predict_track_word(input dcc_ser_cmd_t c, output dcc_ser_res_t r);
        logic [7:0]  instr;
        logic [7:0]  hi;
        logic [7:0]  lo;
        int unsigned closer;
        int unsigned nbytes;
        int unsigned total;
        int unsigned rel;
        int unsigned slot;
        r  = '0;
        lo = c.locomotive_address[7:0];
        if ((c.operation == OP_THROTTLE || c.operation == OP_RESET_PKT) && regs.track_power)
        begin
            if (c.operation == OP_THROTTLE)
            begin
                instr = INSTR_BASE | {2'b00, c.direction_bit, c.speed_step};
                if (c.locomotive_address > SHORT_ADDR_MAX)
                begin
                    hi = LONG_PREFIX | {2'b00, c.locomotive_address[13:8]};
                    staged_bytes = '{hi, lo, instr, hi ^ lo ^ instr};
                    staged_long  = 1'b1;
                end
                else
                begin
                    staged_bytes = '{lo, instr, lo ^ instr, 8'h00};
                    staged_long  = 1'b0;
                end
            end
            else
            begin
                staged_bytes = '{default: 8'h00};
                staged_long  = 1'b0;
            end
            staged_valid = 1'b1;
            r.long_form  = staged_long;
            r.accepted   = 1'b1;
        end
        else if (c.operation == OP_TICK && regs.track_power)
        begin
            closer = (regs.closer_bits == 0) ? 1 : regs.closer_bits;
            nbytes = line_long ? 4 : 3;
            total  = regs.preamble_bits + nbytes * 9 + closer;
            // a register change can leave the position past the end: treat as boundary
            if (bit_pos >= total)
                bit_pos = 0;
            if (bit_pos == 0 && staged_valid)
            begin
                line_bytes   = staged_bytes;
                line_long    = staged_long;
                staged_valid = 1'b0;
                nbytes       = line_long ? 4 : 3;
                total        = regs.preamble_bits + nbytes * 9 + closer;
            end
            if (bit_pos < regs.preamble_bits)
                r.line_bit = 1'b1;
            else if (bit_pos - regs.preamble_bits < nbytes * 9)
            begin
                rel  = bit_pos - regs.preamble_bits;
                slot = rel % 9;
                r.line_bit = (slot == 0) ? 1'b0 : line_bytes[rel / 9][8 - slot];
            end
            else
                r.line_bit = 1'b1;
            r.bit_valid = 1'b1;
            r.long_form = line_long;
            if (bit_pos + 1 >= total)
            begin
                r.packet_last = 1'b1;
                bit_pos       = 0;
            end
            else
                bit_pos = bit_pos + 1;
        end
    endtask

    function automatic int field_differs(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $error("%s expected %0b actual %0b", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dcc_ser_res_t want;
        if (!rst_n)
        begin
            regs.preamble_bits = PREAMBLE_RESET;
            regs.closer_bits   = CLOSER_RESET;
            regs.track_power   = 1'b1;
            staged_bytes       = '{default: 8'h00};
            staged_long        = 1'b0;
            staged_valid       = 1'b0;
            line_bytes         = '{8'hFF, 8'h00, 8'hFF, 8'h00};
            line_long          = 1'b0;
            bit_pos            = 0;
            track_words_q.delete();
            errors             = 0;
            mismatches        <= 0;
            words_due         <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PREAMBLE: regs.preamble_bits = cfg_data;
                    REG_CLOSER:   regs.closer_bits   = cfg_data[3:0];
                    REG_POWER:    regs.track_power   = cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd_valid && !cmd_stall)
            begin
                predict_track_word(cmd_word, want);
                track_words_q.push_back(want);
            end
            if (res_valid && !res_stall)
            begin
                if (track_words_q.size() == 0)
                begin
                    $error("result word with nothing expected: %p", res_word);
                    errors++;
                end
                else
                begin
                    want = track_words_q.pop_front();
                    errors += field_differs("bit_valid", want.bit_valid, res_word.bit_valid);
                    errors += field_differs("line_bit", want.line_bit, res_word.line_bit);
                    errors += field_differs("packet_last", want.packet_last,
                                            res_word.packet_last);
                    errors += field_differs("long_form", want.long_form, res_word.long_form);
                    errors += field_differs("accepted", want.accepted, res_word.accepted);
                end
            end
            mismatches <= errors;
            words_due  <= track_words_q.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: clock, reset, command and register stimulus, verdict.
// Depends on dcc_speed_packet_serializer, dcc_ser_pkg and dcc_bitstream_checker.
module tb_top;
    import dcc_ser_pkg::*;

    localparam logic [1:0]             OP_UNUSED   = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE   = 2'd3;
    localparam int                     CYCLE_LIMIT = 200000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cmd_valid = 1'b0;
    logic                   cmd_stall;
    dcc_ser_cmd_t           cmd_word  = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    dcc_ser_res_t           res_word;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     mismatches;
    int                     words_due;
    int                     cycles    = 0;
    int                     send_gap_pct = 0;
    int                     stall_pct    = 0;

    dcc_speed_packet_serializer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dcc_bitstream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_word   (cmd_word),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_word   (res_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        res_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic set_idling(input int gap_pct, input int stall_rate);
        send_gap_pct = gap_pct;
        stall_pct   <= stall_rate;
    endtask

    // offers one command word, returns at the edge that takes it
    task automatic issue(input logic [1:0] op, input logic [13:0] addr,
                         input logic [4:0] speed, input logic dir);
        dcc_ser_cmd_t c;
        c.operation          = op;
        c.locomotive_address = addr;
        c.speed_step         = speed;
        c.direction_bit      = dir;
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic issue_random(input int load_pct);
        int          pick;
        logic [1:0]  op;
        logic [13:0] addr;
        pick = $urandom_range(99);
        if (pick < load_pct)
            op = ($urandom_range(3) == 0) ? OP_RESET_PKT : OP_THROTTLE;
        else if (pick < load_pct + 2)
            op = OP_UNUSED;
        else
            op = OP_TICK;
        case ($urandom_range(3))
            0:       addr = 14'($urandom_range(127));
            1:       addr = ($urandom_range(1) != 0) ? SHORT_ADDR_MAX : SHORT_ADDR_MAX + 14'd1;
            default: addr = 14'($urandom_range(16383));
        endcase
        issue(op, addr, 5'($urandom_range(31)), 1'($urandom_range(1)));
    endtask

    task automatic wait_quiet();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [4:0] pre, input logic [4:0] clo,
                             input logic [4:0] pwr, input int words, input int load_pct);
        wait_quiet();
        write_reg(REG_PREAMBLE, pre);
        write_reg(REG_CLOSER, clo);
        write_reg(REG_POWER, pwr);
        repeat (words) issue_random(load_pct);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(8, 77);
        // first bits come from the idle packet
        repeat (3) issue(OP_TICK, 14'd0, 5'd0, 1'b0);
        issue(OP_THROTTLE, 14'd0, 5'd0, 1'b0);
        issue(OP_THROTTLE, SHORT_ADDR_MAX, 5'd31, 1'b1);
        issue(OP_THROTTLE, SHORT_ADDR_MAX + 14'd1, 5'd0, 1'b1);
        issue(OP_THROTTLE, 14'h3FFF, 5'd31, 1'b1);
        issue(OP_THROTTLE, 14'h2AAA, 5'h0A, 1'b0);
        issue(OP_THROTTLE, 14'h1555, 5'h15, 1'b1);
        issue(OP_RESET_PKT, 14'h3FFF, 5'd31, 1'b1);
        issue(OP_UNUSED, 14'h3FFF, 5'd31, 1'b1);
        issue(OP_THROTTLE, 14'd3, 5'd7, 1'b1);
        repeat (10) issue(OP_TICK, 14'h3FFF, 5'd31, 1'b1);

        run_phase(5'd16, 5'd1, 5'd1, 180, 15);
        // long preamble, rare loads so packets repeat
        run_phase(5'd31, 5'd8, 5'd1, 200, 3);
        // upper data bit set on the closer write: 15 closing ones
        run_phase(5'd10, 5'h1F, 5'd1, 200, 20);

        set_idling(77, 8);
        // no preamble, zero closer acts as one
        run_phase(5'd0, 5'd0, 5'd1, 200, 10);
        // power off: loads refused, ticks silent, position held
        run_phase(5'd20, 5'd3, 5'h1E, 80, 20);

        set_idling(0, 0);
        wait_quiet();
        write_reg(REG_SPARE, 5'($urandom_range(31)));
        run_phase(5'd12, 5'h14, 5'h03, 220, 2);
        run_phase(5'($urandom_range(31, 10)), 5'($urandom_range(8, 1)), 5'd1, 300, 12);

        wait_quiet();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
